[rtl/wvde_pkg.sv]
// wind vane direction estimator: shared package
// holds payload types, controller commands/status, fsm states and the vane bin table
// no dependencies
package wvde_pkg;

   localparam int unsigned DEG_STEP    = 45;
   localparam int unsigned FULL_CIRCLE = 360;
   localparam logic [3:0]  BIN_RESET   = 4'd5;
   localparam logic [3:0]  BIN_LAST    = 4'd15;
   localparam int unsigned COUNT_MAX   = 63;

   typedef enum logic [0:0] {
      KIND_STORE   = 1'b0,
      KIND_COMPUTE = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [9:0] vane_sample;
   } req_data_type;

   typedef struct packed {
      logic [8:0] direction_deg;
      logic [3:0] window_start;
      logic [5:0] window_count;
   } rsp_data_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HIST,
      ST_SCAN,
      ST_WEIGHT,
      ST_DIV,
      ST_DONE
   } ctl_state_type;

   typedef struct packed {
      logic store;
      logic hist_clear;
      logic hist_step;
      logic scan_step;
      logic weight_step;
      logic div_load;
      logic div_step;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic hist_done;
      logic scan_done;
      logic weight_done;
      logic div_done;
   } dp_status_type;

   // strict thresholds, highest first
   function automatic logic [3:0] vane_to_bin(input logic [9:0] v);
      logic [3:0] bin;
      if      (v > 10'd940) bin = 4'd12;
      else if (v > 10'd890) bin = 4'd14;
      else if (v > 10'd820) bin = 4'd13;
      else if (v > 10'd785) bin = 4'd0;
      else if (v > 10'd690) bin = 4'd15;
      else if (v > 10'd630) bin = 4'd10;
      else if (v > 10'd590) bin = 4'd11;
      else if (v > 10'd455) bin = 4'd2;
      else if (v > 10'd400) bin = 4'd1;
      else if (v > 10'd285) bin = 4'd8;
      else if (v > 10'd240) bin = 4'd9;
      else if (v > 10'd180) bin = 4'd6;
      else if (v > 10'd125) bin = 4'd7;
      else if (v > 10'd90)  bin = 4'd4;
      else if (v > 10'd80)  bin = 4'd3;
      else                  bin = BIN_RESET;
      return bin;
   endfunction

endpackage

[rtl/wvde_ctrl.sv]
// wind vane direction estimator: controller state machine
// sequences histogram, window scan, weighting, division and result load
// depends on wvde_pkg
module wvde_ctrl import wvde_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  kind_type      req_kind,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_kind == KIND_COMPUTE) state_in = ST_HIST;
         end
         ST_HIST: begin
            if (status.hist_done) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_WEIGHT;
         end
         ST_WEIGHT: begin
            if (status.weight_done) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.store      = req_valid && req_kind == KIND_STORE;
            cmd.hist_clear = req_valid && req_kind == KIND_COMPUTE;
         end
         ST_HIST:   cmd.hist_step = 1'b1;
         ST_SCAN:   cmd.scan_step = 1'b1;
         ST_WEIGHT: begin
            cmd.weight_step = !status.weight_done;
            cmd.div_load    = status.weight_done;
         end
         ST_DIV:    cmd.div_step = 1'b1;
         ST_DONE:   cmd.out_load = out_free;
         default:   cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/wvde_dpath.sv]
// wind vane direction estimator: datapath
// sample ring memory, histogram, window scan, weighted sum, restoring divider, result register
// depends on wvde_pkg
module wvde_dpath import wvde_pkg::*; #(
   parameter int SAMPLE_DEPTH = 32,
   parameter int WINDOW_BINS  = 5
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   input  req_data_type  req_data,
   output dp_status_type status,
   output rsp_data_type  rsp_data
);

   localparam int AW  = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
   localparam int CW  = $clog2(SAMPLE_DEPTH + 1);
   localparam int WSW = $clog2(15 * SAMPLE_DEPTH + 1);
   localparam int NW  = WSW + 6;
   localparam int DCW = $clog2(NW);
   localparam logic [AW-1:0]  WP_LAST  = AW'(SAMPLE_DEPTH - 1);
   localparam logic [CW-1:0]  IDX_END  = CW'(SAMPLE_DEPTH);
   localparam logic [4:0]     J_LAST   = 5'(WINDOW_BINS - 1);
   localparam logic [4:0]     J_END    = 5'(WINDOW_BINS);
   localparam logic [DCW-1:0] DIV_LAST = DCW'(NW - 1);

   // sample ring
   logic [3:0]              ring_mem_ff [SAMPLE_DEPTH];
   logic [SAMPLE_DEPTH-1:0] ring_valid_ff;
   logic [AW-1:0]           wp_ff, wp_in;
   logic [3:0]              rd_bin_ff;
   logic                    rd_valid_ff;
   logic [AW-1:0]           rd_addr;
   logic                    rd_issue;
   logic [3:0]              acc_bin;

   // histogram and counters
   logic [CW-1:0]  hist_ff [16];
   logic [3:0]     hist_addr;
   logic [CW-1:0]  hist_rd;
   logic           pend_ff, pend_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [3:0]     s_ff, s_in;
   logic [4:0]     j_ff, j_in;
   logic [CW-1:0]  sum_ff, sum_in;
   logic [CW-1:0]  total;
   logic [CW-1:0]  best_total_ff, best_total_in;
   logic [3:0]     best_start_ff, best_start_in;
   logic [WSW-1:0] wsum_ff, wsum_in;

   // divider
   logic [CW-1:0]  rem_ff, rem_in;
   logic [NW-1:0]  quo_ff, quo_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic [CW:0]    shifted;
   logic           ge;

   // result
   rsp_data_type   rsp_ff;
   logic [10:0]    dir_sum;
   logic [9:0]     dir_half;
   logic [8:0]     dir_deg;
   logic [8:0]     cnt_ext;

   assign rd_addr  = idx_ff[AW-1:0];
   assign rd_issue = cmd.hist_step && (idx_ff != IDX_END);
   assign acc_bin  = rd_valid_ff ? rd_bin_ff : BIN_RESET;

   // one read port: histogram update while filling, window address otherwise
   assign hist_addr = pend_ff         ? acc_bin :
                      cmd.weight_step ? best_start_ff + j_ff[3:0] :
                                        s_ff + j_ff[3:0];
   assign hist_rd   = hist_ff[hist_addr];
   assign total     = sum_ff + hist_rd;

   assign status.hist_done   = (idx_ff == IDX_END);
   assign status.scan_done   = (s_ff == BIN_LAST) && (j_ff == J_LAST);
   assign status.weight_done = (j_ff == J_END);
   assign status.div_done    = (dcnt_ff == DIV_LAST);

   assign wp_in = (wp_ff == WP_LAST) ? '0 : wp_ff + AW'(1);

   always_ff @(posedge clock) begin
      if (cmd.store) ring_mem_ff[wp_ff] <= vane_to_bin(req_data.vane_sample);
      rd_bin_ff <= ring_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_valid_ff <= '0;
         wp_ff         <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         if (cmd.store) begin
            ring_valid_ff[wp_ff] <= 1'b1;
            wp_ff                <= wp_in;
         end
         rd_valid_ff <= ring_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hist_clear) begin
         for (int b = 0; b < 16; b++) hist_ff[b] <= '0;
      end else if (pend_ff) begin
         hist_ff[acc_bin] <= hist_rd + CW'(1);
      end
   end

   assign shifted = {rem_ff, quo_ff[NW-1]};
   assign ge      = (shifted >= (CW+1)'(best_total_ff));

   always_comb begin
      pend_in       = rd_issue;
      idx_in        = idx_ff;
      s_in          = s_ff;
      j_in          = j_ff;
      sum_in        = sum_ff;
      best_total_in = best_total_ff;
      best_start_in = best_start_ff;
      wsum_in       = wsum_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dcnt_in       = dcnt_ff;
      if (cmd.hist_clear) begin
         idx_in        = '0;
         s_in          = '0;
         j_in          = '0;
         sum_in        = '0;
         best_total_in = '0;
         best_start_in = '0;
      end else if (rd_issue) begin
         idx_in = idx_ff + CW'(1);
      end
      if (cmd.scan_step) begin
         if (j_ff == J_LAST) begin
            // window complete: strict compare keeps lowest start on ties
            if (total > best_total_ff) begin
               best_total_in = total;
               best_start_in = s_ff;
            end
            sum_in = '0;
            j_in   = '0;
            s_in   = s_ff + 4'd1;
            if (status.scan_done) begin
               j_in    = 5'd1;
               wsum_in = '0;
            end
         end else begin
            sum_in = total;
            j_in   = j_ff + 5'd1;
         end
      end
      if (cmd.weight_step) begin
         wsum_in = wsum_ff + WSW'(j_ff[3:0]) * WSW'(hist_rd);
         j_in    = j_ff + 5'd1;
      end
      if (cmd.div_load) begin
         quo_in  = NW'(wsum_ff) * NW'(DEG_STEP);
         rem_in  = '0;
         dcnt_in = '0;
      end else if (cmd.div_step) begin
         rem_in  = ge ? CW'(shifted - (CW+1)'(best_total_ff)) : shifted[CW-1:0];
         quo_in  = {quo_ff[NW-2:0], ge};
         dcnt_in = dcnt_ff + DCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         idx_ff  <= '0;
         s_ff    <= '0;
         j_ff    <= '0;
         dcnt_ff <= '0;
      end else begin
         pend_ff <= pend_in;
         idx_ff  <= idx_in;
         s_ff    <= s_in;
         j_ff    <= j_in;
         dcnt_ff <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff        <= sum_in;
      best_total_ff <= best_total_in;
      best_start_ff <= best_start_in;
      wsum_ff       <= wsum_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
   end

   // quotient never exceeds 45 * (bins - 1), so ten bits hold it
   assign dir_sum  = 11'(best_start_ff) * 11'(DEG_STEP) + 11'(quo_ff[9:0]);
   assign dir_half = dir_sum[10:1];
   assign dir_deg  = (best_total_ff == '0)            ? 9'd0 :
                     (dir_half >= 10'(FULL_CIRCLE))   ? 9'(dir_half - 10'(FULL_CIRCLE)) :
                                                        dir_half[8:0];
   assign cnt_ext  = 9'(best_total_ff);

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.direction_deg <= dir_deg;
         rsp_ff.window_start  <= best_start_ff;
         rsp_ff.window_count  <= (cnt_ext > 9'(COUNT_MAX)) ? 6'(COUNT_MAX) : cnt_ext[5:0];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

[rtl/wind_vane_direction_estimator.sv]
// wind vane direction estimator: top level
// joins the controller and the datapath; depends on wvde_pkg, wvde_ctrl, wvde_dpath
//
//   channel  ports                            direction  payload
//   req      req_valid req_ready req_data     in         kind, vane_sample
//   rsp      rsp_valid rsp_ready rsp_data     out        direction_deg, window_start,
//                                                        window_count
//
// reset marks every ring entry as bin 5 by valid bits.
// a compute transaction walks the ring through the single memory read port, then runs the
// one-bin-per-cycle window scan, the weighting and the divider.
// a result waits in the output register; stores are still taken while it waits, and a
// following compute holds in its last state until that register is free.
module wind_vane_direction_estimator import wvde_pkg::*; #(
   parameter int SAMPLE_DEPTH = 32,
   parameter int WINDOW_BINS  = 5
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   wvde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wvde_dpath #(
      .SAMPLE_DEPTH (SAMPLE_DEPTH),
      .WINDOW_BINS  (WINDOW_BINS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

[sim/wind_vane_direction_estimator_tb.sv]
`timescale 1ns / 1ps
// testbench for wind_vane_direction_estimator: directed table, then clustered random vane data
// each result is checked against a table value or a local histogram and window model; depends on wvde_pkg and rtl
module wind_vane_direction_estimator_tb;
   import wvde_pkg::*;

   localparam int SAMPLE_DEPTH = 32;
   localparam int WINDOW_BINS  = 5;
   localparam int NUM_BINS     = 16;
   localparam int RANDOM_ITEMS = 830;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 1000000;

   // ascending thresholds; the bin follows from how many of them a reading exceeds
   localparam logic [14:0][9:0] VANE_EDGE = {10'd940, 10'd890, 10'd820, 10'd785, 10'd690,
      10'd630, 10'd590, 10'd455, 10'd400, 10'd285, 10'd240, 10'd180, 10'd125, 10'd90, 10'd80};
   localparam logic [15:0][3:0] BIN_BY_RANK = {4'd12, 4'd14, 4'd13, 4'd0, 4'd15, 4'd10, 4'd11,
      4'd2, 4'd1, 4'd8, 4'd9, 4'd6, 4'd7, 4'd4, 4'd3, 4'd5};

   // every ring entry at bin 5: best window starts at bin 1 and holds all 32 samples
   localparam rsp_data_type RESET_HEADING = {9'd112, 4'd1, 6'd32};

   typedef struct packed {
      req_data_type stim;
      logic         has_golden;
      rsp_data_type golden;
   } table_row_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_data_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_data_type rsp_data;

   logic [3:0]    vane_ring [SAMPLE_DEPTH];
   int unsigned   ring_wr;
   rsp_data_type  pending_heading [$];
   table_row_type directed_rows [$];
   int            errors        = 0;
   int            send_idle_pct = 0;
   int            rsp_stall_pct = 0;
   int unsigned   cycle_count   = 0;

   wind_vane_direction_estimator #(
      .SAMPLE_DEPTH(SAMPLE_DEPTH),
      .WINDOW_BINS (WINDOW_BINS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [3:0] bin_of_reading(input logic [9:0] reading);
      int rank;
      rank = 0;
      for (int k = 0; k < 15; k++) begin
         if (reading > VANE_EDGE[k]) rank++;
      end
      return BIN_BY_RANK[rank];
   endfunction

   function automatic rsp_data_type heading_of_ring();
      int unsigned  hist [NUM_BINS];
      int unsigned  best_total, best_start, window_sum, weight_sum, deg;
      rsp_data_type heading;
      best_total = 0;
      best_start = 0;
      weight_sum = 0;
      deg        = 0;
      foreach (hist[b]) hist[b] = 0;
      for (int k = 0; k < SAMPLE_DEPTH; k++) hist[vane_ring[k]]++;
      for (int s = 0; s < NUM_BINS; s++) begin
         window_sum = 0;
         for (int j = 0; j < WINDOW_BINS; j++) window_sum += hist[(s + j) % NUM_BINS];
         // strict compare keeps the lowest start on a tie
         if (window_sum > best_total) begin
            best_total = window_sum;
            best_start = s;
         end
      end
      if (best_total != 0) begin
         for (int j = 1; j < WINDOW_BINS; j++) begin
            weight_sum += j * hist[(best_start + j) % NUM_BINS];
         end
         deg = ((best_start * DEG_STEP + (weight_sum * DEG_STEP) / best_total) >> 1)
               % FULL_CIRCLE;
      end
      heading.direction_deg = 9'(deg);
      heading.window_start  = 4'(best_start);
      heading.window_count  = 6'((best_total > COUNT_MAX) ? COUNT_MAX : best_total);
      return heading;
   endfunction

   // half the readings around a drifting prevailing direction, the rest threshold edges and noise
   function automatic logic [9:0] random_reading(input int center);
      int v;
      case ($urandom_range(3))
         0: v = int'($urandom_range(1023));
         1: v = int'(VANE_EDGE[$urandom_range(14)]) + int'($urandom_range(2)) - 1;
         default: v = center + int'($urandom_range(80)) - 40;
      endcase
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return 10'(v);
   endfunction

   task automatic add_row(input kind_type kind, input logic [9:0] reading,
                          input logic has_golden, input rsp_data_type golden);
      table_row_type row;
      row.stim.kind        = kind;
      row.stim.vane_sample = reading;
      row.has_golden       = has_golden;
      row.golden           = golden;
      directed_rows.push_back(row);
   endtask

   // drives one transaction and updates the local ring or queues the expected heading once it is accepted
   task automatic apply_transaction(input req_data_type item, input logic has_golden,
                                    input rsp_data_type golden);
      rsp_data_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (item.kind == KIND_STORE) begin
         vane_ring[ring_wr] = bin_of_reading(item.vane_sample);
         ring_wr = (ring_wr == SAMPLE_DEPTH - 1) ? 0 : ring_wr + 1;
      end else begin
         predicted = heading_of_ring();
         pending_heading.push_back(has_golden ? golden : predicted);
      end
   endtask

   always @(posedge clock) begin : heading_check
      rsp_data_type golden;
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_heading.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual dir %0d start %0d count %0d",
                     $time, rsp_data.direction_deg, rsp_data.window_start,
                     rsp_data.window_count);
         end else begin
            golden = pending_heading.pop_front();
            if (rsp_data.direction_deg !== golden.direction_deg) begin
               errors++;
               $display("%0t: direction_deg expected %0d actual %0d",
                        $time, golden.direction_deg, rsp_data.direction_deg);
            end
            if (rsp_data.window_start !== golden.window_start) begin
               errors++;
               $display("%0t: window_start expected %0d actual %0d",
                        $time, golden.window_start, rsp_data.window_start);
            end
            if (rsp_data.window_count !== golden.window_count) begin
               errors++;
               $display("%0t: window_count expected %0d actual %0d",
                        $time, golden.window_count, rsp_data.window_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_heading.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      req_data_type item;
      int           center;
      for (int k = 0; k < SAMPLE_DEPTH; k++) vane_ring[k] = BIN_RESET;
      ring_wr = 0;
      center  = 512;

      // compute right after reset, twice in a row, with the sample field ignored
      add_row(KIND_COMPUTE, 10'h3FF, 1'b1, RESET_HEADING);
      add_row(KIND_COMPUTE, 10'h000, 1'b1, RESET_HEADING);
      // field extremes and both sides of several thresholds
      add_row(KIND_STORE, 10'd0,    1'b0, '0);
      add_row(KIND_STORE, 10'd1023, 1'b0, '0);
      add_row(KIND_STORE, 10'd940,  1'b0, '0);
      add_row(KIND_STORE, 10'd941,  1'b0, '0);
      add_row(KIND_STORE, 10'd80,   1'b0, '0);
      add_row(KIND_STORE, 10'd81,   1'b0, '0);
      add_row(KIND_STORE, 10'd90,   1'b0, '0);
      add_row(KIND_STORE, 10'd91,   1'b0, '0);
      add_row(KIND_STORE, 10'd785,  1'b0, '0);
      add_row(KIND_STORE, 10'd786,  1'b0, '0);
      add_row(KIND_STORE, 10'd400,  1'b0, '0);
      add_row(KIND_STORE, 10'd401,  1'b0, '0);
      add_row(KIND_STORE, 10'd455,  1'b0, '0);
      add_row(KIND_STORE, 10'd456,  1'b0, '0);
      add_row(KIND_COMPUTE, 10'h155, 1'b0, '0);
      add_row(KIND_STORE, 10'd690,  1'b0, '0);
      add_row(KIND_STORE, 10'd691,  1'b0, '0);
      add_row(KIND_STORE, 10'h2AA,  1'b0, '0);
      add_row(KIND_STORE, 10'h155,  1'b0, '0);
      add_row(KIND_COMPUTE, 10'h2AA, 1'b0, '0);

      send_idle_pct = 11;
      rsp_stall_pct = 69;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         apply_transaction(directed_rows[r].stim, directed_rows[r].has_golden,
                           directed_rows[r].golden);
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 69 : 0;
         rsp_stall_pct = (phase == 0) ? 69 : (phase == 1) ? 11 : 0;
         for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
            // prevailing direction drifts now and then
            if ($urandom_range(39) == 0) center = int'($urandom_range(1023));
            item.kind = ($urandom_range(5) == 0) ? KIND_COMPUTE : KIND_STORE;
            item.vane_sample = (item.kind == KIND_STORE) ? random_reading(center)
                                                         : 10'($urandom);
            apply_transaction(item, 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      while (pending_heading.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/wvde_pkg.sv
rtl/wvde_ctrl.sv
rtl/wvde_dpath.sv
rtl/wind_vane_direction_estimator.sv
sim/wind_vane_direction_estimator_tb.sv
